### rtl/ebs_pkg.sv
// shared constants and types for the ewma throughput / bitrate select block
// used by ebs_divider, ebs_ewma and ewma_throughput_bitrate_select
package ebs_pkg;

   localparam int RATE_REGS   = 4;
   localparam int RATE_SEL_W  = 2;
   localparam int KBPS_W      = 16;
   localparam int AVG_W       = 24;
   localparam int FRAC_W      = 8;
   localparam int ALPHA_W     = 9;
   localparam int COUNT_W     = 3;
   localparam int BYTES_W     = 24;
   localparam int SECS_W      = 16;
   localparam int BYTE_SHIFT  = 11;
   localparam int DIVIDEND_W  = BYTES_W + BYTE_SHIFT;
   localparam int DIVISOR_W   = 26;
   localparam int DIV_CNT_W   = 6;
   localparam int MS_PER_S    = 1000;
   localparam int ACC_W       = 32;
   localparam int MAC_CNT_W   = 4;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 9'd256;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 9'd128;
   localparam logic [COUNT_W-1:0] RATE_COUNT_RESET = 3'd4;
   localparam logic [KBPS_W-1:0]  CAP_RESET       = 16'd1500;

   typedef enum logic [2:0] {
      REG_ALPHA      = 3'd0,
      REG_RATE_COUNT = 3'd1,
      REG_RATE_0     = 3'd2,
      REG_RATE_1     = 3'd3,
      REG_RATE_2     = 3'd4,
      REG_RATE_3     = 3'd5,
      REG_CAP        = 3'd6
   } reg_idx_type;

endpackage

### rtl/ewma_throughput_bitrate_select.sv
// top level: ewma throughput estimator with bitrate table selection
// depends on ebs_pkg, ebs_divider, ebs_ewma
//
// requests arrive on the req_ channel (valid/stall), one result per request
// leaves on the rsp_ channel. req_cmd 1 reports a finished chunk: its
// throughput, bytes*8/(seconds*1000) in q16.8 kbps, comes from a bit-serial
// divider, is limited to cap_kbps and folded into the running average by a
// bit-serial multiply-accumulate over the 9 alpha bits; a zero duration skips
// the divider. req_cmd 0 picks a bitrate: the first request after an empty
// average takes entry 0, otherwise the table is scanned one entry per cycle.
// one item is in work at a time; req_stall is high from the transfer until
// the result moves to the output register, and the next transfer can follow
// in the cycle after. the output register lets a new request in while
// rsp_stall holds the last result. reset clears the average and the chosen
// rate and loads the register defaults; csr_ registers are written over an
// apb-style port, and the user must write them only while idle: the block
// itself does not enforce it.
module ewma_throughput_bitrate_select #(
   parameter int NUM_RATES = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [ebs_pkg::BYTES_W-1:0]       req_chunk_bytes,
   input  logic [ebs_pkg::SECS_W-1:0]        req_duration_s,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ebs_pkg::KBPS_W-1:0]        rsp_selected_kbps,
   output logic [ebs_pkg::AVG_W-1:0]         rsp_throughput_q8,
   output logic                              rsp_event_kind,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ebs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ebs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ebs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int RATE_LIMIT = (NUM_RATES < ebs_pkg::RATE_REGS) ? NUM_RATES
                                                                : ebs_pkg::RATE_REGS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MAC,
      ST_SCAN,
      ST_DONE
   } state_type;

   // configuration registers
   logic [ebs_pkg::ALPHA_W-1:0]  alpha_ff;
   logic [ebs_pkg::COUNT_W-1:0]  rate_count_ff;
   logic [ebs_pkg::KBPS_W-1:0]   rate_ff [ebs_pkg::RATE_REGS];
   logic [ebs_pkg::KBPS_W-1:0]   cap_ff;
   logic                         csr_write;
   ebs_pkg::reg_idx_type         csr_idx;

   // block state
   state_type                    state_ff, state_in;
   logic                         cmd_ff, cmd_in;
   logic [ebs_pkg::AVG_W-1:0]    avg_ff, avg_in;
   logic [ebs_pkg::KBPS_W-1:0]   chosen_ff, chosen_in;
   logic [ebs_pkg::AVG_W-1:0]    nq_ff, nq_in;
   logic [ebs_pkg::COUNT_W-1:0]  idx_ff, idx_in;
   logic [ebs_pkg::KBPS_W-1:0]   prev_ff, prev_in;
   logic                         mac_start_ff, mac_start_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ebs_pkg::KBPS_W-1:0]   rsp_kbps_ff, rsp_kbps_in;
   logic [ebs_pkg::AVG_W-1:0]    rsp_avg_ff, rsp_avg_in;
   logic                         rsp_kind_ff, rsp_kind_in;

   logic                              div_start;
   logic [ebs_pkg::DIVISOR_W-1:0]     divisor_w;
   logic                              div_done;
   logic [ebs_pkg::DIVIDEND_W-1:0]    div_quotient;
   logic                              mac_done;
   logic [ebs_pkg::AVG_W-1:0]         mac_result;
   logic [ebs_pkg::ALPHA_W-1:0]       alpha_eff;
   logic [ebs_pkg::AVG_W-1:0]         cap_q8;
   logic [ebs_pkg::AVG_W-1:0]         sat_w;
   logic [ebs_pkg::KBPS_W-1:0]        rate_sel;
   logic [ebs_pkg::DIVISOR_W-1:0]     rate_x768;
   logic [ebs_pkg::DIVISOR_W-1:0]     avg_x2;
   logic [ebs_pkg::COUNT_W-1:0]       n_valid;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = ebs_pkg::reg_idx_type'(csr_paddr[ebs_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff      <= ebs_pkg::ALPHA_RESET;
         rate_count_ff <= ebs_pkg::RATE_COUNT_RESET;
         rate_ff[0]    <= '0;
         rate_ff[1]    <= '0;
         rate_ff[2]    <= '0;
         rate_ff[3]    <= '0;
         cap_ff        <= ebs_pkg::CAP_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            ebs_pkg::REG_ALPHA:      alpha_ff      <= csr_pwdata[ebs_pkg::ALPHA_W-1:0];
            ebs_pkg::REG_RATE_COUNT: rate_count_ff <= csr_pwdata[ebs_pkg::COUNT_W-1:0];
            ebs_pkg::REG_RATE_0:     rate_ff[0]    <= csr_pwdata[ebs_pkg::KBPS_W-1:0];
            ebs_pkg::REG_RATE_1:     rate_ff[1]    <= csr_pwdata[ebs_pkg::KBPS_W-1:0];
            ebs_pkg::REG_RATE_2:     rate_ff[2]    <= csr_pwdata[ebs_pkg::KBPS_W-1:0];
            ebs_pkg::REG_RATE_3:     rate_ff[3]    <= csr_pwdata[ebs_pkg::KBPS_W-1:0];
            ebs_pkg::REG_CAP:        cap_ff        <= csr_pwdata[ebs_pkg::KBPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         ebs_pkg::REG_ALPHA:      csr_prdata = ebs_pkg::CSR_DATA_W'(alpha_ff);
         ebs_pkg::REG_RATE_COUNT: csr_prdata = ebs_pkg::CSR_DATA_W'(rate_count_ff);
         ebs_pkg::REG_RATE_0:     csr_prdata = ebs_pkg::CSR_DATA_W'(rate_ff[0]);
         ebs_pkg::REG_RATE_1:     csr_prdata = ebs_pkg::CSR_DATA_W'(rate_ff[1]);
         ebs_pkg::REG_RATE_2:     csr_prdata = ebs_pkg::CSR_DATA_W'(rate_ff[2]);
         ebs_pkg::REG_RATE_3:     csr_prdata = ebs_pkg::CSR_DATA_W'(rate_ff[3]);
         ebs_pkg::REG_CAP:        csr_prdata = ebs_pkg::CSR_DATA_W'(cap_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // datapath around the serial units
   assign req_stall = (state_ff != ST_IDLE);
   assign divisor_w = {10'd0, req_duration_s} * ebs_pkg::DIVISOR_W'(ebs_pkg::MS_PER_S);
   assign div_start = req_valid && !req_stall && req_cmd && (req_duration_s != '0);
   assign alpha_eff = (alpha_ff > ebs_pkg::ALPHA_ONE) ? ebs_pkg::ALPHA_ONE : alpha_ff;
   assign cap_q8    = {cap_ff, 8'd0};
   assign sat_w     = (div_quotient > ebs_pkg::DIVIDEND_W'(cap_q8)) ? cap_q8
                                                 : div_quotient[ebs_pkg::AVG_W-1:0];
   assign rate_sel  = rate_ff[idx_ff[ebs_pkg::RATE_SEL_W-1:0]];
   assign rate_x768 = ebs_pkg::DIVISOR_W'({rate_sel, 9'd0})
                    + ebs_pkg::DIVISOR_W'({rate_sel, 8'd0});
   assign avg_x2    = ebs_pkg::DIVISOR_W'({avg_ff, 1'b0});

   always_comb begin
      if (rate_count_ff == '0) begin
         n_valid = 3'd1;
      end else if (rate_count_ff > ebs_pkg::COUNT_W'(RATE_LIMIT)) begin
         n_valid = ebs_pkg::COUNT_W'(RATE_LIMIT);
      end else begin
         n_valid = rate_count_ff;
      end
   end

   ebs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({req_chunk_bytes, 11'd0}),
      .divisor  (divisor_w),
      .done     (div_done),
      .quotient (div_quotient)
   );

   ebs_ewma u_ewma (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_start_ff),
      .alpha  (alpha_eff),
      .sample (nq_ff),
      .avg    (avg_ff),
      .done   (mac_done),
      .result (mac_result)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      avg_in       = avg_ff;
      chosen_in    = chosen_ff;
      nq_in        = nq_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      mac_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kbps_in  = rsp_kbps_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_kind_in  = rsp_kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               if (req_cmd) begin
                  if (req_duration_s == '0) begin
                     nq_in        = cap_q8;
                     mac_start_in = 1'b1;
                     state_in     = ST_MAC;
                  end else begin
                     state_in = ST_DIV;
                  end
               end else if (avg_ff == '0) begin
                  chosen_in = rate_ff[0];
                  avg_in    = {rate_ff[0], 8'd0};
                  state_in  = ST_DONE;
               end else begin
                  idx_in   = 3'd1;
                  prev_in  = rate_ff[0];
                  state_in = ST_SCAN;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               nq_in        = sat_w;
               mac_start_in = 1'b1;
               state_in     = ST_MAC;
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               avg_in   = mac_result;
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            priority if (idx_ff >= n_valid || avg_x2 < rate_x768) begin
               chosen_in = prev_ff;
               state_in  = ST_DONE;
            end else begin
               prev_in = rate_sel;
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kbps_in  = chosen_ff;
               rsp_avg_in   = avg_ff;
               rsp_kind_in  = cmd_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_ff       <= '0;
         chosen_ff    <= '0;
         mac_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         chosen_ff    <= chosen_in;
         mac_start_ff <= mac_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      nq_ff       <= nq_in;
      idx_ff      <= idx_in;
      prev_ff     <= prev_in;
      rsp_kbps_ff <= rsp_kbps_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_selected_kbps = rsp_kbps_ff;
   assign rsp_throughput_q8 = rsp_avg_ff;
   assign rsp_event_kind    = rsp_kind_ff;

`ifndef SYNTH
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared without a finished item");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide phase");

   a_mac_done_in_mac: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_MAC)
      else $error("average update finished outside its phase");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff >= 3'd1 && idx_ff <= ebs_pkg::COUNT_W'(RATE_LIMIT))
      else $error("table scan index out of range");
`endif

endmodule

### rtl/ebs_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on ebs_pkg
module ebs_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ebs_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [ebs_pkg::DIVISOR_W-1:0]     divisor,
   output logic                              done,
   output logic [ebs_pkg::DIVIDEND_W-1:0]    quotient
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [ebs_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ebs_pkg::DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [ebs_pkg::DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [ebs_pkg::DIVISOR_W-1:0]   dsr_ff, dsr_in;
   logic [ebs_pkg::DIVISOR_W:0]     rem_shift;
   logic [ebs_pkg::DIVISOR_W+1:0]   diff;
   logic                            fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[ebs_pkg::DIVIDEND_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, dsr_ff};
      fits      = !diff[ebs_pkg::DIVISOR_W+1];
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ebs_pkg::DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[ebs_pkg::DIVISOR_W-1:0] : rem_shift[ebs_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ebs_pkg::DIV_CNT_W'(ebs_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/ebs_ewma.sv
// bit-serial weighted average: (a*sample + (256-a)*avg)/256, one weight bit per cycle
// depends on ebs_pkg
module ebs_ewma (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ebs_pkg::ALPHA_W-1:0]    alpha,
   input  logic [ebs_pkg::AVG_W-1:0]      sample,
   input  logic [ebs_pkg::AVG_W-1:0]      avg,
   output logic                           done,
   output logic [ebs_pkg::AVG_W-1:0]      result
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [ebs_pkg::MAC_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ebs_pkg::ALPHA_W-1:0]     a_sh_ff, a_sh_in;
   logic [ebs_pkg::ALPHA_W-1:0]     b_sh_ff, b_sh_in;
   logic [ebs_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic [ebs_pkg::ACC_W-1:0]       add_a, add_b;

   always_comb begin
      add_a   = a_sh_ff[ebs_pkg::ALPHA_W-1] ? ebs_pkg::ACC_W'(sample) : '0;
      add_b   = b_sh_ff[ebs_pkg::ALPHA_W-1] ? ebs_pkg::ACC_W'(avg) : '0;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_sh_in = alpha;
         b_sh_in = ebs_pkg::ALPHA_ONE - alpha;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in  = {acc_ff[ebs_pkg::ACC_W-2:0], 1'b0} + add_a + add_b;
         a_sh_in = {a_sh_ff[ebs_pkg::ALPHA_W-2:0], 1'b0};
         b_sh_in = {b_sh_ff[ebs_pkg::ALPHA_W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == ebs_pkg::MAC_CNT_W'(ebs_pkg::ALPHA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      acc_ff  <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff[ebs_pkg::ACC_W-1:ebs_pkg::FRAC_W];

endmodule

### dv/tb_ewma_throughput_bitrate_select.sv
// self-checking testbench for ewma_throughput_bitrate_select: a directed table, then
// randomised phases under several register settings, checked against a local predictor
// depends on ebs_pkg and the rtl top level ewma_throughput_bitrate_select
module tb_ewma_throughput_bitrate_select;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RATES   = 4;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 60;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 205;
   localparam logic [63:0] RATE_MARGIN = 64'd768;
   localparam logic CMD_SEGMENT = 1'b0;
   localparam logic CMD_CHUNK   = 1'b1;
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECKED} row_kind_type;

   typedef struct packed {
      logic [ebs_pkg::KBPS_W-1:0] kbps;
      logic [ebs_pkg::AVG_W-1:0]  avg_q8;
      logic                       kind;
   } rate_result_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [2:0]                     reg_sel;
      logic [ebs_pkg::CSR_DATA_W-1:0] wdata;
      logic                           cmd;
      logic [ebs_pkg::BYTES_W-1:0]    bytes;
      logic [ebs_pkg::SECS_W-1:0]     secs;
      logic [ebs_pkg::KBPS_W-1:0]     want_kbps;
      logic [ebs_pkg::AVG_W-1:0]      want_avg;
   } stim_row_type;

   // register columns unused on item rows, expected columns used on checked rows only
   localparam stim_row_type DIRECTED [35] = '{
      '{ROW_CHECKED, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CHECKED, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'hFF_FFFF, 16'hFFFF, 16'd0, 24'd0},
      '{ROW_CHECKED, ebs_pkg::REG_ALPHA, 32'd0, CMD_CHUNK, 24'd0, 16'd0, 16'd0, 24'd192000},
      '{ROW_CHECKED, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'hFF_FFFF, 16'hFFFF, 16'd0,
        24'd192000},
      '{ROW_CFG, ebs_pkg::REG_ALPHA, 32'hFFFF_FF00, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_RATE_0, 32'd300, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_RATE_1, 32'd750, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_RATE_2, 32'd1200, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_RATE_3, 32'd2500, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_CAP, 32'hFFFF_FFFF, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CHECKED, ebs_pkg::REG_ALPHA, 32'd0, CMD_CHUNK, 24'hFF_FFFF, 16'd1, 16'd0,
        24'hFF_FF00},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CHECKED, ebs_pkg::REG_ALPHA, 32'd0, CMD_CHUNK, 24'd1, 16'hFFFF, 16'd2500, 24'd0},
      '{ROW_CHECKED, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd300, 24'd76800},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_CHUNK, 24'hFF_FFFF, 16'hFFFF, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_CHUNK, 24'd500000, 16'd2, 16'd0, 24'd0},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_ALPHA, 32'd511, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_RATE_COUNT, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_CHUNK, 24'd1000000, 16'd4, 16'd0, 24'd0},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_RATE_COUNT, 32'd7, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_CAP, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CHECKED, ebs_pkg::REG_ALPHA, 32'd0, CMD_CHUNK, 24'hFF_FFFF, 16'd0, 16'd300, 24'd0},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, REG_UNMAPPED, 32'hFFFF_FFFF, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_RATE_0, 32'd65535, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_RATE_COUNT, 32'd2, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_ALPHA, 32'd128, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_CFG, ebs_pkg::REG_CAP, 32'd1500, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_CHUNK, 24'd187500, 16'd1, 16'd0, 24'd0},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_CHUNK, 24'd12345, 16'd3, 16'd0, 24'd0},
      '{ROW_ITEM, ebs_pkg::REG_ALPHA, 32'd0, CMD_SEGMENT, 24'd0, 16'd0, 16'd0, 24'd0}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_cmd = 1'b0;
   logic [ebs_pkg::BYTES_W-1:0]    req_chunk_bytes = '0;
   logic [ebs_pkg::SECS_W-1:0]     req_duration_s = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [ebs_pkg::KBPS_W-1:0]     rsp_selected_kbps;
   logic [ebs_pkg::AVG_W-1:0]      rsp_throughput_q8;
   logic                           rsp_event_kind;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [ebs_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [ebs_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [ebs_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // predictor copy of the registers and of the estimator state
   logic [ebs_pkg::ALPHA_W-1:0] cfg_alpha = ebs_pkg::ALPHA_RESET;
   logic [ebs_pkg::COUNT_W-1:0] cfg_rate_count = ebs_pkg::RATE_COUNT_RESET;
   logic [ebs_pkg::KBPS_W-1:0]  cfg_rate [ebs_pkg::RATE_REGS] = '{default: '0};
   logic [ebs_pkg::KBPS_W-1:0]  cfg_cap = ebs_pkg::CAP_RESET;
   logic [ebs_pkg::AVG_W-1:0]   est_avg = '0;
   logic [ebs_pkg::KBPS_W-1:0]  est_rate = '0;

   rate_result_type awaited[$];
   rate_result_type head;
   int              errors = 0;
   int              cycle_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   logic            hold_request = 1'b0;
   logic            hold_done = 1'b0;
   int              hold_left = 0;

   ewma_throughput_bitrate_select #(
      .NUM_RATES(NUM_RATES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_chunk_bytes   (req_chunk_bytes),
      .req_duration_s    (req_duration_s),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_selected_kbps (rsp_selected_kbps),
      .rsp_throughput_q8 (rsp_throughput_q8),
      .rsp_event_kind    (rsp_event_kind),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rate_result_type predict_selection(
         input logic cmd,
         input logic [ebs_pkg::BYTES_W-1:0] bytes,
         input logic [ebs_pkg::SECS_W-1:0] secs);
      logic [ebs_pkg::ALPHA_W-1:0] a;
      logic [63:0]                 cap_q8;
      logic [63:0]                 meas;
      logic [63:0]                 acc;
      logic [63:0]                 lhs;
      int                          n;
      int                          k;
      rate_result_type             res;
      if (cmd == CMD_CHUNK) begin
         a = (cfg_alpha > ebs_pkg::ALPHA_ONE) ? ebs_pkg::ALPHA_ONE : cfg_alpha;
         cap_q8 = 64'(cfg_cap) << ebs_pkg::FRAC_W;
         if (secs == '0) begin
            meas = cap_q8;
         end else begin
            meas = (64'(bytes) << ebs_pkg::BYTE_SHIFT) / (64'(secs) * ebs_pkg::MS_PER_S);
            if (meas > cap_q8) meas = cap_q8;
         end
         acc = 64'(a) * meas + 64'(ebs_pkg::ALPHA_ONE - a) * 64'(est_avg);
         est_avg = acc[ebs_pkg::FRAC_W +: ebs_pkg::AVG_W];
      end else if (est_avg == '0) begin
         // first request after an empty average seeds it from entry 0
         est_rate = cfg_rate[0];
         est_avg = {cfg_rate[0], {ebs_pkg::FRAC_W{1'b0}}};
      end else begin
         n = (cfg_rate_count == '0) ? 1 : int'(cfg_rate_count);
         if (n > NUM_RATES) n = NUM_RATES;
         if (n > ebs_pkg::RATE_REGS) n = ebs_pkg::RATE_REGS;
         lhs = 64'(est_avg) * 2;
         k = 1;
         while (k < n && lhs >= 64'(cfg_rate[k]) * RATE_MARGIN) k++;
         est_rate = cfg_rate[(k - 1) % ebs_pkg::RATE_REGS];
      end
      res.kbps = est_rate;
      res.avg_q8 = est_avg;
      res.kind = cmd;
      return res;
   endfunction

   task automatic csr_write(input logic [2:0] sel,
                            input logic [ebs_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ebs_pkg::CSR_ADDR_W'({sel, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (sel)
         ebs_pkg::REG_ALPHA:      cfg_alpha = data[ebs_pkg::ALPHA_W-1:0];
         ebs_pkg::REG_RATE_COUNT: cfg_rate_count = data[ebs_pkg::COUNT_W-1:0];
         ebs_pkg::REG_RATE_0:     cfg_rate[0] = data[ebs_pkg::KBPS_W-1:0];
         ebs_pkg::REG_RATE_1:     cfg_rate[1] = data[ebs_pkg::KBPS_W-1:0];
         ebs_pkg::REG_RATE_2:     cfg_rate[2] = data[ebs_pkg::KBPS_W-1:0];
         ebs_pkg::REG_RATE_3:     cfg_rate[3] = data[ebs_pkg::KBPS_W-1:0];
         ebs_pkg::REG_CAP:        cfg_cap = data[ebs_pkg::KBPS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_item(input logic cmd, input logic [ebs_pkg::BYTES_W-1:0] bytes,
                            input logic [ebs_pkg::SECS_W-1:0] secs, input logic checked,
                            input rate_result_type want);
      rate_result_type predicted;
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_chunk_bytes <= bytes;
      req_duration_s  <= secs;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predicted = predict_selection(cmd, bytes, secs);
      awaited.push_back(checked ? want : predicted);
   endtask

   task automatic drain_results();
      while (awaited.size() != 0) @(posedge clock);
   endtask

   task automatic configure_random();
      logic [ebs_pkg::KBPS_W-1:0]  rates [ebs_pkg::RATE_REGS];
      logic [ebs_pkg::KBPS_W-1:0]  swap;
      logic [ebs_pkg::ALPHA_W-1:0] a;
      logic [ebs_pkg::KBPS_W-1:0]  c;
      logic [31:0]                 junk;
      int                          i;
      int                          j;
      case ($urandom_range(5))
         0: a = '0;
         1: a = ebs_pkg::ALPHA_ONE;
         2: a = ebs_pkg::ALPHA_W'($urandom_range(257, 511));
         default: a = ebs_pkg::ALPHA_W'($urandom_range(1, 255));
      endcase
      case ($urandom_range(9))
         0: c = '0;
         1: c = '1;
         default: c = ebs_pkg::KBPS_W'($urandom_range(100, 20000));
      endcase
      for (i = 0; i < ebs_pkg::RATE_REGS; i++) begin
         rates[i] = ebs_pkg::KBPS_W'($urandom_range(0, c));
      end
      if ($urandom_range(9) == 0) begin
         for (i = 0; i < ebs_pkg::RATE_REGS; i++) rates[i] = ebs_pkg::KBPS_W'($urandom);
      end else begin
         for (i = 0; i < ebs_pkg::RATE_REGS - 1; i++) begin
            for (j = 0; j < ebs_pkg::RATE_REGS - 1 - i; j++) begin
               if (rates[j] > rates[j+1]) begin
                  swap = rates[j];
                  rates[j] = rates[j+1];
                  rates[j+1] = swap;
               end
            end
         end
         if ($urandom_range(9) == 0) rates[0] = '0;
      end
      junk = $urandom;
      csr_write(ebs_pkg::REG_ALPHA, {junk[31:ebs_pkg::ALPHA_W], a});
      junk = $urandom;
      csr_write(ebs_pkg::REG_RATE_COUNT,
                {junk[31:ebs_pkg::COUNT_W], ebs_pkg::COUNT_W'($urandom_range(7))});
      for (i = 0; i < ebs_pkg::RATE_REGS; i++) begin
         junk = $urandom;
         csr_write(3'(ebs_pkg::REG_RATE_0 + i), {junk[31:ebs_pkg::KBPS_W], rates[i]});
      end
      junk = $urandom;
      csr_write(ebs_pkg::REG_CAP, {junk[31:ebs_pkg::KBPS_W], c});
   endtask

   task automatic pick_item(output logic cmd, output logic [ebs_pkg::BYTES_W-1:0] bytes,
                            output logic [ebs_pkg::SECS_W-1:0] secs);
      logic [63:0] scaled;
      int unsigned kbps;
      int unsigned sel;
      cmd = 1'($urandom_range(1));
      sel = $urandom_range(99);
      bytes = ebs_pkg::BYTES_W'($urandom);
      secs = ebs_pkg::SECS_W'($urandom);
      if (sel < 8) begin
         secs = '0;
      end else if (sel < 14) begin
         bytes = '0;
         secs = ebs_pkg::SECS_W'($urandom_range(1, 60));
      end else if (sel >= 24) begin
         // chunk sized to land near the table range
         secs = ebs_pkg::SECS_W'($urandom_range(1, 40));
         kbps = $urandom_range(0, 2 * cfg_cap + 100);
         scaled = 64'(kbps) * secs * 125 + $urandom_range(0, 124);
         bytes = (scaled > 64'hFF_FFFF) ? '1 : scaled[ebs_pkg::BYTES_W-1:0];
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t result with nothing awaited: kbps %0d avg %0d kind %0d", $time,
                     rsp_selected_kbps, rsp_throughput_q8, rsp_event_kind);
         end else begin
            head = awaited.pop_front();
            check_field("selected_kbps", 32'(head.kbps), 32'(rsp_selected_kbps));
            check_field("throughput_q8", 32'(head.avg_q8), 32'(rsp_throughput_q8));
            check_field("event_kind", 32'(head.kind), 32'(rsp_event_kind));
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      stim_row_type                row;
      rate_result_type             want;
      logic                        cmd;
      logic [ebs_pkg::BYTES_W-1:0] bytes;
      logic [ebs_pkg::SECS_W-1:0]  secs;
      int                          r;
      int                          ph;
      int                          n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < $size(DIRECTED); r++) begin
         row = DIRECTED[r];
         want = {row.want_kbps, row.want_avg, row.cmd};
         if (row.kind == ROW_CFG) begin
            req_valid <= 1'b0;
            drain_results();
            csr_write(row.reg_sel, row.wdata);
         end else begin
            send_item(row.cmd, row.bytes, row.secs, row.kind == ROW_CHECKED, want);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         req_valid <= 1'b0;
         drain_results();
         configure_random();
         send_idle_pct = (ph < 3) ? 10 : (ph < 6) ? 50 : 0;
         recv_idle_pct <= (ph < 3) ? 50 : (ph < 6) ? 10 : 0;
         if (ph == 0) hold_request <= 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < send_idle_pct) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 60)) @(posedge clock);
            end
            pick_item(cmd, bytes, secs);
            send_item(cmd, bytes, secs, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && awaited.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/ebs_pkg.sv
rtl/ebs_divider.sv
rtl/ebs_ewma.sv
rtl/ewma_throughput_bitrate_select.sv
dv/tb_ewma_throughput_bitrate_select.sv
